// File: src/rfifo_pkg.sv
// ----------------------------------------------------------------------------
// rfifo_pkg
// Shared types and constants for the ring FIFO with drop and peek.
// ----------------------------------------------------------------------------
package rfifo_pkg;

    // Default geometry of the entry store.
    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;

    // Fixed widths of the operation fields and of the capacity register.
    localparam int OP_W  = 2;
    localparam int CNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_DROP = 2'd2,
        OP_PEEK = 2'd3
    } op_t;

    // Outcome of one operation as decided by the pointer control.
    typedef struct packed {
        logic             ok;
        logic             rd;     // a successful pop or peek reads the store
        logic             wr;     // a successful push writes the store
        logic             full;
        logic             empty;
        logic [CNT_W-1:0] count;
    } rfifo_status_t;

endpackage

// File: src/rfifo_ram.sv
// ----------------------------------------------------------------------------
// rfifo_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rfifo_ram #(
    parameter int W = 32,
    parameter int D = 16,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/rfifo_ctrl.sv
// ----------------------------------------------------------------------------
// rfifo_ctrl
// Head, tail, count and capacity registers of the ring FIFO, with the
// decision for each operation and the address it presents to the store.
// ----------------------------------------------------------------------------
module rfifo_ctrl #(
    parameter int DEPTH = rfifo_pkg::DEPTH_DEF,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rfifo_pkg::CNT_W-1:0] cfg_cap,
    input  logic                        op_go,
    input  logic [rfifo_pkg::OP_W-1:0]  op,
    input  logic [rfifo_pkg::CNT_W-1:0] amount,
    output rfifo_pkg::rfifo_status_t    status,
    output logic [AW-1:0]               addr
);

    localparam int CW = rfifo_pkg::CNT_W;
    // Arithmetic width: holds an index or a count plus one bit of carry.
    localparam int SW = ((AW > CW) ? AW : CW) + 1;
    localparam int CNT_MAX = (1 << CW) - 1;
    localparam logic [CW-1:0] CAP_MAX = CW'((DEPTH < CNT_MAX) ? DEPTH : CNT_MAX);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cap_reg, cap_next;

    logic [SW-1:0] cap_x;
    logic [SW-1:0] step;
    logic [SW-1:0] head_sum;
    logic [SW-1:0] head_adv;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_adv;
    rfifo_pkg::op_t op_code;

    assign op_code = rfifo_pkg::op_t'(op);
    assign cap_x   = SW'(cap_reg);

    // Index arithmetic wraps with one compare and subtract: the sum stays
    // below twice the capacity whenever the result is used.
    always_comb
    begin
        step     = (op_code == rfifo_pkg::OP_POP) ? SW'(1) : SW'(amount);
        head_sum = SW'(head_reg) + step;
        head_adv = (head_sum >= cap_x) ? head_sum - cap_x : head_sum;
        tail_sum = SW'(tail_reg) + SW'(1);
        tail_adv = (tail_sum >= cap_x) ? tail_sum - cap_x : tail_sum;
    end

    // Capacity register write: zero means one, above the store depth clamps.
    always_comb
    begin
        if (cfg_cap == '0)
        begin
            cap_next = CW'(1);
        end
        else if (cfg_cap > CAP_MAX)
        begin
            cap_next = CAP_MAX;
        end
        else
        begin
            cap_next = cfg_cap;
        end
    end

    always_comb
    begin
        status       = '0;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        addr         = head_reg;
        unique case (op_code)
            rfifo_pkg::OP_PUSH:
            begin
                addr = tail_reg;
                if (count_reg < cap_reg)
                begin
                    status.ok  = 1'b1;
                    status.wr  = 1'b1;
                    tail_next  = tail_adv[AW-1:0];
                    count_next = count_reg + CW'(1);
                end
            end
            rfifo_pkg::OP_POP:
            begin
                if (count_reg != '0)
                begin
                    status.ok  = 1'b1;
                    status.rd  = 1'b1;
                    head_next  = head_adv[AW-1:0];
                    count_next = count_reg - CW'(1);
                end
            end
            rfifo_pkg::OP_DROP:
            begin
                if (amount <= count_reg)
                begin
                    status.ok  = 1'b1;
                    head_next  = head_adv[AW-1:0];
                    count_next = count_reg - amount;
                end
            end
            rfifo_pkg::OP_PEEK:
            begin
                addr = head_adv[AW-1:0];
                if (amount < count_reg)
                begin
                    status.ok = 1'b1;
                    status.rd = 1'b1;
                end
            end
            default:
            begin
                status.ok = 1'b0;
            end
        endcase
        status.count = count_next;
        status.full  = (count_next == cap_reg);
        status.empty = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_MAX;
        end
        else if (cfg_we)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= cap_next;
        end
        else if (op_go)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= cap_reg) && (cap_reg != '0))
        else $error("fill count exceeds capacity or capacity is zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (SW'(head_reg) < cap_x) && (SW'(tail_reg) < cap_x))
        else $error("head or tail index outside the capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (op_go && !status.ok && !cfg_we) |=>
            ($stable(count_reg) && $stable(head_reg) && $stable(tail_reg)))
        else $error("refused operation changed the FIFO state");

endmodule

// File: src/ring_fifo_with_drop_and_peek.sv
// ----------------------------------------------------------------------------
// ring_fifo_with_drop_and_peek
// Circular FIFO with push, pop, multi-entry drop and peek at an offset.
// ----------------------------------------------------------------------------
// A result appears in the cycle after its operation is accepted.
// One operation per cycle unless a result stalls; the store is a RAM with
// one write and one registered read port, and each op uses at most one.
// Reset: head, tail and fill count clear, capacity goes to DEPTH (max 31);
// entry contents are undefined until written and are never read before then.
// ----------------------------------------------------------------------------
module ring_fifo_with_drop_and_peek #(
    parameter int DEPTH = rfifo_pkg::DEPTH_DEF,
    parameter int WIDTH = rfifo_pkg::WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    // Capacity register write channel.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rfifo_pkg::CNT_W-1:0] capacity_in_use,

    // Operation channel.
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rfifo_pkg::OP_W-1:0]  op,
    input  logic [WIDTH-1:0]            push_data,
    input  logic [rfifo_pkg::CNT_W-1:0] amount,

    // Result channel.
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        ok,
    output logic [WIDTH-1:0]            read_data,
    output logic [rfifo_pkg::CNT_W-1:0] fill_count,
    output logic                        is_full,
    output logic                        is_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                     in_xfer;
    logic                     cfg_xfer;
    logic                     out_valid_reg, out_valid_next;
    rfifo_pkg::rfifo_status_t status;
    rfifo_pkg::rfifo_status_t res_reg;
    logic [AW-1:0]            addr;
    logic [WIDTH-1:0]         ram_rdata;

    // cfg_ready is tied high. Writes must be issued only while no operation is
    // in flight; the block itself does not enforce this and has no interlock.
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // The result register is the only buffer between the two channels. A
    // new operation is taken whenever that register is empty or its result
    // is transferred in the same cycle, so the queue keeps streaming.
    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    rfifo_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_xfer),
        .cfg_cap (capacity_in_use),
        .op_go   (in_xfer),
        .op      (op),
        .amount  (amount),
        .status  (status),
        .addr    (addr)
    );

    // A push writes at the tail at the accepting edge. A pop or peek reads
    // at the same edge; the read data then sits in the RAM output register
    // and holds, since no other read is issued while the result waits. A
    // write followed by a read of the same entry in the next cycle sees the
    // new data because the write has already landed.
    rfifo_ram #(
        .W (WIDTH),
        .D (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (in_xfer && status.wr),
        .waddr (addr),
        .wdata (push_data),
        .re    (in_xfer && status.rd),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    assign out_valid_next = in_xfer || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result fields are payload and carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_reg <= status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = res_reg.ok;
    assign read_data  = res_reg.rd ? ram_rdata : '0;
    assign fill_count = res_reg.count;
    assign is_full    = res_reg.full;
    assign is_empty   = res_reg.empty;

    // A refused operation never returns data.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.ok || (read_data == '0)))
        else $error("refused operation returned nonzero data");

    // The capacity is at least one, so full and empty never coincide.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.full && res_reg.empty))
        else $error("result reports full and empty together");

endmodule

// File: dv/tb_ring_fifo_with_drop_and_peek.sv
// ----------------------------------------------------------------------------
// tb_ring_fifo_with_drop_and_peek
// Self-checking testbench for the ring FIFO with drop and peek.
// ----------------------------------------------------------------------------
// The testbench keeps its own image of the queue: the entry store, the head
// and tail positions, the fill count and the capacity register. Each operation
// transfer updates that image and queues the result it should produce. A
// checker compares every result transfer, field by field, with the oldest
// queued result. Directed tests cover the empty and full limits, every
// refusal, pointer wrap and a capacity of zero. Random traffic then runs
// under a range of capacity settings, including ones above the store depth,
// with random idle cycles on both channels except in one phase.
// ----------------------------------------------------------------------------
module tb_ring_fifo_with_drop_and_peek;

    localparam int DEPTH     = rfifo_pkg::DEPTH_DEF;
    localparam int WIDTH     = rfifo_pkg::WIDTH_DEF;
    localparam int IDLE_PCT  = 11;
    localparam int RUN_LIMIT = 400000;
    localparam int PHASES    = 10;
    localparam int PHASE_OPS = 130;

    typedef struct packed {
        logic                        ok;
        logic [WIDTH-1:0]            read_data;
        logic [rfifo_pkg::CNT_W-1:0] fill_count;
        logic                        is_full;
        logic                        is_empty;
    } fifo_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;

    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [rfifo_pkg::CNT_W-1:0] capacity_in_use = rfifo_pkg::CNT_W'(DEPTH);

    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [rfifo_pkg::OP_W-1:0]  op = rfifo_pkg::OP_PUSH;
    logic [WIDTH-1:0]            push_data = '0;
    logic [rfifo_pkg::CNT_W-1:0] amount = '0;

    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        ok;
    logic [WIDTH-1:0]            read_data;
    logic [rfifo_pkg::CNT_W-1:0] fill_count;
    logic                        is_full;
    logic                        is_empty;

    // Image of the queue as the block should hold it after every accepted
    // transfer.
    logic [WIDTH-1:0]            mirror_slots [DEPTH];
    int unsigned                 head_pos = 0;
    int unsigned                 tail_pos = 0;
    int unsigned                 held_entries = 0;
    logic [rfifo_pkg::CNT_W-1:0] capacity_setting = rfifo_pkg::CNT_W'(DEPTH);

    fifo_result_t                pending_results [$];
    int unsigned                 mismatch_count = 0;

    // While set, neither side inserts idle cycles.
    bit                          no_idle = 1'b0;

    ring_fifo_with_drop_and_peek #(
        .DEPTH(DEPTH),
        .WIDTH(WIDTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .capacity_in_use(capacity_in_use),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .push_data      (push_data),
        .amount         (amount),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .read_data      (read_data),
        .fill_count     (fill_count),
        .is_full        (is_full),
        .is_empty       (is_empty)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // A capacity of zero behaves as one slot, and anything above the store
    // depth behaves as the full depth.
    function automatic int unsigned usable_capacity();
        if (capacity_setting == 0)
            return 1;
        if (capacity_setting > DEPTH)
            return DEPTH;
        return int'(capacity_setting);
    endfunction

    // Applies one operation to the queue image and returns its result. A
    // refused operation leaves the image untouched.
    function automatic fifo_result_t apply_fifo_op(rfifo_pkg::op_t kind,
                                                   logic [WIDTH-1:0] data,
                                                   logic [rfifo_pkg::CNT_W-1:0] count_arg);
        int unsigned  cap;
        fifo_result_t res;
        cap = usable_capacity();
        res = '0;
        case (kind)
            rfifo_pkg::OP_PUSH:
                if (held_entries < cap)
                begin
                    mirror_slots[tail_pos] = data;
                    tail_pos = (tail_pos + 1) % cap;
                    held_entries++;
                    res.ok = 1'b1;
                end
            rfifo_pkg::OP_POP:
                if (held_entries != 0)
                begin
                    res.read_data = mirror_slots[head_pos];
                    head_pos = (head_pos + 1) % cap;
                    held_entries--;
                    res.ok = 1'b1;
                end
            rfifo_pkg::OP_DROP:
                if (count_arg <= held_entries)
                begin
                    head_pos = (head_pos + count_arg) % cap;
                    held_entries -= count_arg;
                    res.ok = 1'b1;
                end
            rfifo_pkg::OP_PEEK:
                if (count_arg < held_entries)
                begin
                    res.read_data = mirror_slots[(head_pos + count_arg) % cap];
                    res.ok = 1'b1;
                end
            default:
            begin
                res.ok = 1'b0;
            end
        endcase
        res.fill_count = held_entries[rfifo_pkg::CNT_W-1:0];
        res.is_full    = (held_entries == cap);
        res.is_empty   = (held_entries == 0);
        return res;
    endfunction

    function automatic void compare_field(string field, logic [WIDTH-1:0] want_val,
                                          logic [WIDTH-1:0] got);
        if (got !== want_val)
        begin
            $error("%s: expected %0h, actual %0h", field, want_val, got);
            mismatch_count++;
        end
    endfunction

    // Presents one operation, with random idle cycles ahead of it, and holds
    // it until the transfer happens.
    task automatic send_op(rfifo_pkg::op_t kind, logic [WIDTH-1:0] data,
                           logic [rfifo_pkg::CNT_W-1:0] count_arg);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= kind;
        push_data <= data;
        amount    <= count_arg;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(apply_fifo_op(kind, data, count_arg));
    endtask

    // Stops sending and waits until every queued result has been checked.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // The capacity register is written only with the block idle. The write
    // also clears the pointers and the count.
    task automatic write_capacity(logic [rfifo_pkg::CNT_W-1:0] value);
        wait_for_results();
        @(negedge clk);
        cfg_valid       <= 1'b1;
        capacity_in_use <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        capacity_setting = value;
        head_pos         = 0;
        tail_pos         = 0;
        held_entries     = 0;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Refusals on an empty queue, and the drop of zero entries that succeeds.
    task automatic test_empty_queue();
        send_op(rfifo_pkg::OP_POP,  32'h1234_5678, 5'd0);
        send_op(rfifo_pkg::OP_PEEK, '0, 5'd0);
        send_op(rfifo_pkg::OP_DROP, '0, 5'd0);
        send_op(rfifo_pkg::OP_DROP, '0, 5'd1);
    endtask

    // Fills a four-slot queue with extreme data, checks every refusal at the
    // full and offset limits, and makes head and tail wrap.
    task automatic test_wrap_and_refusals();
        write_capacity(5'd4);
        send_op(rfifo_pkg::OP_PUSH, 32'h0000_0000, 5'd0);
        send_op(rfifo_pkg::OP_PUSH, 32'hFFFF_FFFF, 5'd31);
        send_op(rfifo_pkg::OP_PUSH, 32'h5555_5555, 5'd0);
        send_op(rfifo_pkg::OP_PUSH, 32'hAAAA_AAAA, 5'd0);
        send_op(rfifo_pkg::OP_PUSH, 32'h1234_5678, 5'd0);
        send_op(rfifo_pkg::OP_PEEK, '0, 5'd3);
        send_op(rfifo_pkg::OP_PEEK, '0, 5'd4);
        send_op(rfifo_pkg::OP_PEEK, '0, 5'd31);
        send_op(rfifo_pkg::OP_DROP, '0, 5'd5);
        send_op(rfifo_pkg::OP_DROP, '0, 5'd2);
        send_op(rfifo_pkg::OP_POP,  '0, 5'd0);
        send_op(rfifo_pkg::OP_PUSH, 32'hC0DE_0001, 5'd0);
        send_op(rfifo_pkg::OP_PUSH, 32'hC0DE_0002, 5'd0);
        send_op(rfifo_pkg::OP_POP,  '0, 5'd0);
        send_op(rfifo_pkg::OP_PEEK, '0, 5'd1);
        send_op(rfifo_pkg::OP_DROP, '0, 5'd2);
    endtask

    // A capacity of zero must behave as a single slot.
    task automatic test_capacity_limits();
        write_capacity(5'd0);
        send_op(rfifo_pkg::OP_PUSH, 32'hDEAD_BEEF, 5'd0);
        send_op(rfifo_pkg::OP_PUSH, 32'hFEED_F00D, 5'd0);
        send_op(rfifo_pkg::OP_PEEK, '0, 5'd0);
        send_op(rfifo_pkg::OP_POP,  '0, 5'd0);
    endtask

    // Random traffic under several capacity settings. Operations lean toward
    // push while the queue is less than half full so that it keeps reaching
    // both limits, and most offsets stay within the fill count.
    task automatic test_random_traffic();
        logic [rfifo_pkg::CNT_W-1:0] phase_caps [PHASES];
        int unsigned                 cap;
        int unsigned                 push_pct;
        int unsigned                 roll;
        rfifo_pkg::op_t              kind;
        logic [rfifo_pkg::CNT_W-1:0] count_arg;
        phase_caps = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd0, 5'd17, 5'd9, 5'd16, 5'd3,
                       rfifo_pkg::CNT_W'($urandom_range(31))};
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_caps[p]);
            no_idle = (p == 3);
            for (int k = 0; k < PHASE_OPS; k++)
            begin
                // Halfway through each phase the sender waits for the queue
                // of results to run dry.
                if (k == PHASE_OPS / 2)
                    wait_for_results();
                cap      = usable_capacity();
                push_pct = (held_entries * 2 < cap) ? 55 : 30;
                roll     = $urandom_range(99);
                if (roll < push_pct)
                    kind = rfifo_pkg::OP_PUSH;
                else if (roll < push_pct + 25)
                    kind = rfifo_pkg::OP_POP;
                else if (roll < push_pct + 40)
                    kind = rfifo_pkg::OP_DROP;
                else
                    kind = rfifo_pkg::OP_PEEK;
                if ($urandom_range(4) == 0)
                    count_arg = rfifo_pkg::CNT_W'($urandom_range(31));
                else
                    count_arg = rfifo_pkg::CNT_W'($urandom_range(held_entries));
                send_op(kind, $urandom(), count_arg);
            end
            no_idle = 1'b0;
        end
    endtask

    // The receiver stalls at random, except during the stretch without idling.
    always @(negedge clk)
        out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);

    // Each result transfer is checked against the oldest queued result.
    always @(posedge clk)
    begin
        fifo_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no result expected");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("ok",         WIDTH'(want.ok),         WIDTH'(ok));
                compare_field("read_data",  want.read_data,          read_data);
                compare_field("fill_count", WIDTH'(want.fill_count), WIDTH'(fill_count));
                compare_field("is_full",    WIDTH'(want.is_full),    WIDTH'(is_full));
                compare_field("is_empty",   WIDTH'(want.is_empty),   WIDTH'(is_empty));
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_queue();
        test_wrap_and_refusals();
        test_capacity_limits();
        test_random_traffic();
        wait_for_results();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
